@@ hw/rtl/eds_pkg.sv @@
package eds_pkg;

  // Field and datapath widths
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 2;
  localparam int MAG_W        = COORD_W + 1;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int FRAC_BITS    = 12;
  localparam int ROOT_SHIFT   = 2 * FRAC_BITS + 2;
  localparam int RESULT_SHIFT = 4;
  localparam int NUM_CELLS    = (SUM_W + ROOT_SHIFT) / 2;
  localparam int ROOT_W       = NUM_CELLS;
  localparam int REM_W        = ROOT_W + 2;
  localparam int DIST_W       = 26;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] first_off_x;
    logic signed [COORD_W-1:0] first_off_y;
    logic signed [COORD_W-1:0] first_off_z;
    logic signed [COORD_W-1:0] second_off_x;
    logic signed [COORD_W-1:0] second_off_y;
    logic signed [COORD_W-1:0] second_off_z;
  } eds_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
  } eds_out_t;

  // State handed from one root cell to the next
  typedef struct packed {
    logic              vld;
    logic [SUM_W-1:0]  pend;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } eds_cell_t;

endpackage

@@ hw/rtl/eds_chan_if.sv @@
interface eds_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/eds_front.sv @@
module eds_front import eds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      req_vld_i,
  input  eds_in_t   req_i,
  output eds_cell_t cell_o
);

  logic                     d_vld_r, sq_vld_r, sum_vld_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [MAG_W-1:0]         mx, my, mz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;

  // Form the offset points and their differences
  assign dx_nxt = DIFF_W'(req_i.first_x) + DIFF_W'(req_i.first_off_x)
                - DIFF_W'(req_i.second_x) - DIFF_W'(req_i.second_off_x);
  assign dy_nxt = DIFF_W'(req_i.first_y) + DIFF_W'(req_i.first_off_y)
                - DIFF_W'(req_i.second_y) - DIFF_W'(req_i.second_off_y);
  assign dz_nxt = DIFF_W'(req_i.first_z) + DIFF_W'(req_i.first_off_z)
                - DIFF_W'(req_i.second_z) - DIFF_W'(req_i.second_off_z);

  // Take magnitudes for the squares
  assign mx = dx_r[DIFF_W-1] ? MAG_W'(-dx_r) : dx_r[MAG_W-1:0];
  assign my = dy_r[DIFF_W-1] ? MAG_W'(-dy_r) : dy_r[MAG_W-1:0];
  assign mz = dz_r[DIFF_W-1] ? MAG_W'(-dz_r) : dz_r[MAG_W-1:0];

  assign sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r   <= 1'b0;
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r   <= req_vld_i;
      sq_vld_r  <= d_vld_r;
      sum_vld_r <= sq_vld_r;
    end
  end

  // Advance payload: difference, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dz_r  <= dz_nxt;
      sqx_r <= SQ_W'(mx) * SQ_W'(mx);
      sqy_r <= SQ_W'(my) * SQ_W'(my);
      sqz_r <= SQ_W'(mz) * SQ_W'(mz);
      sum_r <= sum_nxt;
    end
  end

  assign cell_o.vld  = sum_vld_r;
  assign cell_o.pend = sum_r;
  assign cell_o.rem  = '0;
  assign cell_o.root = '0;

endmodule

@@ hw/rtl/eds_cell.sv @@
module eds_cell import eds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  eds_cell_t cell_i,
  output eds_cell_t cell_o
);

  logic [REM_W-1:0]  rem_sh, trial, rem_nxt;
  logic              ge;
  logic              vld_r;
  logic [SUM_W-1:0]  pend_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  // Bring down the next radicand pair and try one root bit
  assign rem_sh  = {cell_i.rem[REM_W-3:0], cell_i.pend[SUM_W-1 -: 2]};
  assign trial   = {cell_i.root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_nxt = ge ? (rem_sh - trial) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= cell_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pend_r <= {cell_i.pend[SUM_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {cell_i.root[ROOT_W-2:0], ge};
    end
  end

  assign cell_o.vld  = vld_r;
  assign cell_o.pend = pend_r;
  assign cell_o.rem  = rem_r;
  assign cell_o.root = root_r;

endmodule

@@ hw/rtl/euclidean_distance_3d_offset_top.sv @@
// 3D distance between two offset points, about 256 * sqrt(S).
//
// in_ch carries one request: two points and one offset vector per point
// (send zero offsets when unused, zero z fields for a 2D query). out_ch
// returns one distance per request, in request order. Both channels move a
// request at a clock edge where valid and ready are both high.
//
// Path from accept to out_ch.valid: three front stages (difference,
// square, sum), a chain of 31 root cells that each settle one root bit,
// and the rounding output register. Throughput is one request per cycle
// while out_ch.ready stays high.
//
// When the receiver stalls, one further result lands in a skid register and
// in_ch.ready stays high until then; once the skid register is full the whole
// chain holds and in_ch.ready drops until out_ch.ready returns.
//
// Synchronous active-low reset clears all valids; the block comes out of
// reset empty and ready.
module euclidean_distance_3d_offset_top import eds_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  eds_chan_if.sink   in_ch,
  eds_chan_if.source out_ch
);

  logic              en;
  logic              new_vld;
  logic [ROOT_W:0]   rnd;
  eds_out_t          new_data;
  eds_cell_t         cell_q [0:NUM_CELLS];
  logic              out_vld_r, skid_vld_r;
  eds_out_t          out_data_r, skid_data_r;

  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  eds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_vld_i (in_ch.valid),
    .req_i     (in_ch.data),
    .cell_o    (cell_q[0])
  );

  // Chain of root cells, one root bit each
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    eds_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .cell_i (cell_q[i]),
      .cell_o (cell_q[i+1])
    );
  end

  // Round off the root's lowest bit, then drop four more low bits
  assign rnd               = {1'b0, cell_q[NUM_CELLS].root} + (ROOT_W+1)'(1);
  assign new_data.distance = rnd[RESULT_SHIFT+1 +: DIST_W];
  assign new_vld           = cell_q[NUM_CELLS].vld && en;

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      out_vld_r  <= skid_vld_r || new_vld;
      skid_vld_r <= 1'b0;
    end else if (new_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      out_data_r <= skid_vld_r ? skid_data_r : new_data;
    end else if (new_vld) begin
      skid_data_r <= new_data;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  // Skid entry is only ever occupied behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry full while output register empty");

  // Skid entry fills only when the receiver stalled a result
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ch.ready))
    else $error("skid entry filled without a stall");

  // Final remainder stays within the floor-root bound
  a_root_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cell_q[NUM_CELLS].vld |->
      (cell_q[NUM_CELLS].rem <= REM_W'({cell_q[NUM_CELLS].root, 1'b0})))
    else $error("root remainder exceeds twice the root");

endmodule
